FILE: hw/rtl/mvd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvd_pkg
// Shared types and constants for the masked vector distance core.
// ----------------------------------------------------------------------------
package mvd_pkg;

    localparam int ACC_W      = 48;
    localparam int CNT_W      = 13;
    localparam int DIST_W     = 16;
    localparam int CNT_HW_MAX = 8191;

    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam logic [PADDR_W-1:0] REG_METRIC_MODE = 3'd0;

    localparam logic MODE_RMS = 1'b0;
    localparam logic MODE_MAD = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic             mode;
    } job_t;

endpackage : mvd_pkg
`default_nettype wire

FILE: hw/rtl/mvd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvd_front
// Accepts element pairs, forms the per-pair term and accumulates sum and count.
// ----------------------------------------------------------------------------
module mvd_front #(
    parameter int SAMPLE_BITS  = 16,
    parameter int MAX_ELEMENTS = 4096
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          item_valid,
    output logic                         item_ready,
    input  wire  signed [SAMPLE_BITS-1:0] x_sample,
    input  wire  signed [SAMPLE_BITS-1:0] y_sample,
    input  wire                          x_valid,
    input  wire                          y_valid,
    input  wire                          last_element,
    input  wire                          metric_mode,
    input  wire                          queue_full,
    output logic                         push_valid,
    output mvd_pkg::job_t                push_job
);

    localparam int S = SAMPLE_BITS;
    localparam int LIMIT_INT = (MAX_ELEMENTS > mvd_pkg::CNT_HW_MAX) ?
                               mvd_pkg::CNT_HW_MAX : MAX_ELEMENTS;
    localparam logic [mvd_pkg::CNT_W-1:0] COUNT_LIMIT = mvd_pkg::CNT_W'(LIMIT_INT);

    logic                         adv;
    logic signed [S:0]            diff;
    logic [S:0]                   mag;

    logic                         a_valid_reg;
    logic                         a_use_reg;
    logic                         a_last_reg;
    logic                         a_mode_reg;
    logic [S-1:0]                 a_abs_reg;

    logic [2*S-1:0]               sq;
    logic                         b_valid_reg;
    logic                         b_use_reg;
    logic                         b_last_reg;
    logic                         b_mode_reg;
    logic [mvd_pkg::ACC_W-1:0]    b_term_reg;

    logic [mvd_pkg::ACC_W-1:0]    sum_reg;
    logic [mvd_pkg::CNT_W-1:0]    cnt_reg;
    logic                         add;
    logic [mvd_pkg::ACC_W:0]      sum_plus;
    logic [mvd_pkg::ACC_W-1:0]    sum_upd;
    logic [mvd_pkg::CNT_W-1:0]    cnt_upd;

    // Only a last beat waiting on a full queue holds the pipe.
    assign adv        = !(b_valid_reg && b_last_reg && queue_full);
    assign item_ready = adv;

    assign diff = $signed({x_sample[S-1], x_sample}) - $signed({y_sample[S-1], y_sample});
    assign mag  = diff[S] ? (~diff + 1'b1) : diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= item_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_use_reg  <= x_valid & y_valid;
            a_last_reg <= last_element;
            a_mode_reg <= metric_mode;
            a_abs_reg  <= mag[S-1:0];
            b_use_reg  <= a_use_reg;
            b_last_reg <= a_last_reg;
            b_mode_reg <= a_mode_reg;
            b_term_reg <= (a_mode_reg == mvd_pkg::MODE_MAD) ?
                          mvd_pkg::ACC_W'(a_abs_reg) : mvd_pkg::ACC_W'(sq);
        end
    end

    assign sq = (2*S)'(a_abs_reg) * (2*S)'(a_abs_reg);

    assign add      = b_use_reg && (cnt_reg < COUNT_LIMIT);
    assign sum_plus = {1'b0, sum_reg} + {1'b0, b_term_reg};
    assign sum_upd  = !add ? sum_reg :
                      (sum_plus[mvd_pkg::ACC_W] ? {mvd_pkg::ACC_W{1'b1}} :
                                                   sum_plus[mvd_pkg::ACC_W-1:0]);
    assign cnt_upd  = add ? (cnt_reg + 1'b1) : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (adv && b_valid_reg)
        begin
            if (b_last_reg)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_upd;
                cnt_reg <= cnt_upd;
            end
        end
    end

    assign push_valid     = b_valid_reg && b_last_reg && !queue_full;
    assign push_job.sum   = sum_upd;
    assign push_job.count = cnt_upd;
    assign push_job.mode  = b_mode_reg;

endmodule : mvd_front
`default_nettype wire

FILE: hw/rtl/mvd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvd_queue
// Short job queue between the accumulating front and the finishing back.
// ----------------------------------------------------------------------------
module mvd_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push_valid,
    input  mvd_pkg::job_t       push_job,
    output logic                full,
    input  wire                 pop,
    output mvd_pkg::job_t       pop_job,
    output logic                empty
);

    mvd_pkg::job_t                  mem_reg [mvd_pkg::Q_DEPTH];
    logic [mvd_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [mvd_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [mvd_pkg::Q_CNT_W-1:0]    fill_reg;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (fill_reg == mvd_pkg::Q_CNT_W'(mvd_pkg::Q_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push_valid && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule : mvd_queue
`default_nettype wire

FILE: hw/rtl/mvd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvd_back
// Iterative mean (restoring divide) and integer square root, result register.
// ----------------------------------------------------------------------------
module mvd_back (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          queue_empty,
    input  mvd_pkg::job_t                job,
    output logic                         pop,
    output logic                         result_valid,
    input  wire                          result_ready,
    output logic [mvd_pkg::DIST_W-1:0]   distance,
    output logic                         no_data,
    output logic [mvd_pkg::CNT_W-1:0]    used_pairs
);

    localparam int AW = mvd_pkg::ACC_W;
    localparam int CW = mvd_pkg::CNT_W;
    localparam int DW = mvd_pkg::DIST_W;
    localparam int STEP_W = $clog2(AW);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(AW - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(AW / 2 - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    function automatic logic [DW-1:0] sat_dist(input logic [AW-1:0] v);
        logic over;
        over = |v[AW-1:DW];
        return over ? {DW{1'b1}} : v[DW-1:0];
    endfunction

    logic [1:0]         state_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [CW-1:0]      rem_reg;
    logic [CW-1:0]      div_reg;
    logic [AW-1:0]      dvd_reg;
    logic [AW-1:0]      res_reg;
    logic [AW-1:0]      bit_reg;
    logic               mode_reg;
    logic [DW-1:0]      dist_reg;
    logic               nodata_reg;
    logic [CW-1:0]      used_reg;

    logic               result_valid_reg;
    logic [DW-1:0]      distance_reg;
    logic               no_data_reg;
    logic [CW-1:0]      used_pairs_reg;

    logic [CW:0]        trial;
    logic [CW:0]        trial_sub;
    logic               ge;
    logic [AW-1:0]      dvd_shift;
    logic [AW-1:0]      sq_trial;
    logic               sq_ge;
    logic [AW-1:0]      res_step;
    logic               load_out;

    assign trial     = {rem_reg, dvd_reg[AW-1]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign ge        = (trial >= {1'b0, div_reg});
    assign dvd_shift = {dvd_reg[AW-2:0], ge};

    assign sq_trial  = res_reg + bit_reg;
    assign sq_ge     = (dvd_reg >= sq_trial);
    assign res_step  = sq_ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);

    assign pop      = (state_reg == ST_IDLE) && !queue_empty;
    assign load_out = (state_reg == ST_DONE) && (!result_valid_reg || result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        step_reg  <= '0;
                        state_reg <= (job.count == '0) ? ST_DONE : ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (step_reg == DIV_LAST)
                    begin
                        step_reg  <= '0;
                        state_reg <= (mode_reg == mvd_pkg::MODE_MAD) ? ST_DONE : ST_SQRT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_SQRT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == SQRT_LAST)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    dvd_reg    <= job.sum;
                    div_reg    <= job.count;
                    used_reg   <= job.count;
                    mode_reg   <= job.mode;
                    rem_reg    <= '0;
                    dist_reg   <= '0;
                    nodata_reg <= (job.count == '0);
                end
            end
            ST_DIV:
            begin
                rem_reg <= ge ? trial_sub[CW-1:0] : trial[CW-1:0];
                dvd_reg <= dvd_shift;
                res_reg <= '0;
                bit_reg <= AW'(1) << (AW - 2);
                if (step_reg == DIV_LAST)
                begin
                    dist_reg <= sat_dist(dvd_shift);
                end
            end
            ST_SQRT:
            begin
                if (sq_ge)
                begin
                    dvd_reg <= dvd_reg - sq_trial;
                end
                res_reg <= res_step;
                bit_reg <= bit_reg >> 2;
                if (step_reg == SQRT_LAST)
                begin
                    dist_reg <= sat_dist(res_step);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            distance_reg   <= dist_reg;
            no_data_reg    <= nodata_reg;
            used_pairs_reg <= used_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign distance     = distance_reg;
    assign no_data      = no_data_reg;
    assign used_pairs   = used_pairs_reg;

endmodule : mvd_back
`default_nettype wire

FILE: hw/rtl/masked_vector_distance_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// masked_vector_distance_core
// RMS or mean absolute difference of two streamed vectors with missing values.
//
// Item channel (item_valid/item_ready): one element pair per beat, with
// x_valid/y_valid flags and last_element on the final pair. A beat can be
// taken every cycle; item_ready drops only while a last pair waits for room
// in the two-entry job queue.
// Result channel (result_valid/result_ready): one beat per last pair.
// For a vector with used pairs, the back end runs a one-bit-per-cycle
// divider and, in RMS mode only, a two-bits-per-cycle square root. It takes
// a new job only once the previous result is in the result register; with
// several short vectors in a row it sets the pace.
// metric_mode is the APB register at offset 0; pready is always high.
// Reset clears the accumulators, the queue and the result valid flag. When
// the receiver stalls, the result holds; the back end computes the next
// job meanwhile, then the queue fills and item_ready drops.
// ----------------------------------------------------------------------------
module masked_vector_distance_core #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [mvd_pkg::PADDR_W-1:0]         paddr,
    input  wire  [mvd_pkg::PDATA_W-1:0]         pwdata,
    output logic [mvd_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  wire                                 item_valid,
    output logic                                item_ready,
    input  wire  signed [SAMPLE_BITS-1:0]       x_sample,
    input  wire  signed [SAMPLE_BITS-1:0]       y_sample,
    input  wire                                 x_valid,
    input  wire                                 y_valid,
    input  wire                                 last_element,
    output logic                                result_valid,
    input  wire                                 result_ready,
    output logic [mvd_pkg::DIST_W-1:0]          distance,
    output logic                                no_data,
    output logic [mvd_pkg::CNT_W-1:0]           used_pairs
);

    localparam int LIMIT_INT = (MAX_ELEMENTS > mvd_pkg::CNT_HW_MAX) ?
                               mvd_pkg::CNT_HW_MAX : MAX_ELEMENTS;

    logic           metric_mode_reg;
    logic           cfg_wr;
    logic           q_full;
    logic           q_empty;
    logic           q_push;
    logic           q_pop;
    mvd_pkg::job_t  q_push_job;
    mvd_pkg::job_t  q_pop_job;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == mvd_pkg::REG_METRIC_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_mode_reg <= mvd_pkg::MODE_RMS;
        end
        else if (cfg_wr)
        begin
            metric_mode_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr == mvd_pkg::REG_METRIC_MODE) ?
                    mvd_pkg::PDATA_W'(metric_mode_reg) : '0;

    mvd_front #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .x_sample     (x_sample),
        .y_sample     (y_sample),
        .x_valid      (x_valid),
        .y_valid      (y_valid),
        .last_element (last_element),
        .metric_mode  (metric_mode_reg),
        .queue_full   (q_full),
        .push_valid   (q_push),
        .push_job     (q_push_job)
    );

    mvd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .pop_job    (q_pop_job),
        .empty      (q_empty)
    );

    mvd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (q_empty),
        .job          (q_pop_job),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .distance     (distance),
        .no_data      (no_data),
        .used_pairs   (used_pairs)
    );

`ifndef ASSERT_OFF
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> q_full)
        else $error("item stalled without full queue");

    a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && no_data) |-> (distance == '0 && used_pairs == '0))
        else $error("no-data result carries distance or count");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (used_pairs <= mvd_pkg::CNT_W'(LIMIT_INT)))
        else $error("used pair count above limit");
`endif

endmodule : masked_vector_distance_core
`default_nettype wire

FILE: tb/masked_vector_distance_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_vector_distance_core_tb
// Self-checking bench for the masked vector distance core. A directed table
// covers reset state, sample extremes, missing-value flags and long vectors
// in both metrics. It is followed by random vector pairs under four
// handshake idling profiles. Every result beat is checked field by field against
// the table for typed rows, else an in-bench RMS / mean absolute difference model.
// ----------------------------------------------------------------------------
module masked_vector_distance_core_tb;

    localparam int MAX_PAIRS     = 4096;
    localparam int SAMPLE_W      = 16;
    localparam int PAIR_LIMIT    = (MAX_PAIRS > mvd_pkg::CNT_HW_MAX) ?
                                   mvd_pkg::CNT_HW_MAX : MAX_PAIRS;
    localparam longint unsigned SUM_MAX = (64'd1 << mvd_pkg::ACC_W) - 64'd1;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_PAD     = 100;
    localparam int TAIL_PAD      = 200;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PAIRS   = 170;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [mvd_pkg::DIST_W-1:0] dist_val;
        logic                       no_data;
        logic [mvd_pkg::CNT_W-1:0]  used;
    } distance_beat_t;

    typedef struct packed {
        logic                       mode;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic                       xv;
        logic                       yv;
        logic                       last;
        logic [15:0]                reps;
        logic                       typed;
        distance_beat_t             want;
    } vector_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [mvd_pkg::PADDR_W-1:0]   paddr;
    logic [mvd_pkg::PDATA_W-1:0]   pwdata;
    logic [mvd_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;
    logic                          item_valid;
    logic                          item_ready;
    logic signed [SAMPLE_W-1:0]    x_sample;
    logic signed [SAMPLE_W-1:0]    y_sample;
    logic                          x_valid;
    logic                          y_valid;
    logic                          last_element;
    logic                          result_valid;
    logic                          result_ready;
    logic [mvd_pkg::DIST_W-1:0]    distance;
    logic                          no_data;
    logic [mvd_pkg::CNT_W-1:0]     used_pairs;

    longint unsigned run_sum;
    int unsigned     run_pairs;
    logic            cur_mode;
    distance_beat_t  expected_distances[$];
    vector_row_t     directed_rows[$];
    int              fail_count = 0;
    int              readback_errors = 0;
    int              cycle_count = 0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;

    masked_vector_distance_core #(
        .MAX_ELEMENTS (MAX_PAIRS),
        .SAMPLE_BITS  (SAMPLE_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .x_sample     (x_sample),
        .y_sample     (y_sample),
        .x_valid      (x_valid),
        .y_valid      (y_valid),
        .last_element (last_element),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .distance     (distance),
        .no_data      (no_data),
        .used_pairs   (used_pairs)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        distance_beat_t got;
        distance_beat_t want;
        if (rst_n && result_valid && result_ready)
        begin
            got.dist_val = distance;
            got.no_data  = no_data;
            got.used     = used_pairs;
            if (expected_distances.size() == 0)
            begin
                fail_count++;
                if (fail_count + readback_errors <= REPORT_MAX)
                    $display("unexpected result beat: distance %0d no_data %0d used_pairs %0d",
                             got.dist_val, got.no_data, got.used);
            end
            else
            begin
                want = expected_distances.pop_front();
                if (got.dist_val !== want.dist_val || got.no_data !== want.no_data ||
                    got.used !== want.used)
                begin
                    fail_count++;
                    if (fail_count + readback_errors <= REPORT_MAX)
                        $display("result mismatch: distance %0d/%0d no_data %0d/%0d %s %0d/%0d",
                                 want.dist_val, got.dist_val, want.no_data, got.no_data,
                                 "used_pairs (exp/got)", want.used, got.used);
                end
            end
        end
    end

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if (cand * cand <= v)
                root = cand;
        end
        return root;
    endfunction

    // Folds one pair into the running sum; returns 1 with the distance on a last pair.
    function automatic bit accumulate_pair(input logic signed [SAMPLE_W-1:0] xs,
                                           input logic signed [SAMPLE_W-1:0] ys,
                                           input logic xv, input logic yv,
                                           input logic last,
                                           output distance_beat_t res);
        longint          diff;
        longint unsigned mag;
        longint unsigned term;
        longint unsigned quot;
        res = '0;
        if (xv && yv && run_pairs < PAIR_LIMIT)
        begin
            diff = longint'(xs) - longint'(ys);
            mag  = (diff < 0) ? longint'(-diff) : diff;
            term = (cur_mode == mvd_pkg::MODE_MAD) ? mag : mag * mag;
            if (term > SUM_MAX - run_sum)
                run_sum = SUM_MAX;
            else
                run_sum = run_sum + term;
            run_pairs++;
        end
        if (!last)
            return 1'b0;
        if (run_pairs == 0)
            res.no_data = 1'b1;
        else
        begin
            quot = run_sum / run_pairs;
            if (cur_mode == mvd_pkg::MODE_RMS)
                quot = floor_sqrt(quot);
            res.dist_val = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
            res.used     = run_pairs[mvd_pkg::CNT_W-1:0];
        end
        run_sum   = 0;
        run_pairs = 0;
        return 1'b1;
    endfunction

    function automatic void add_row(input logic mode, input int x, input int y,
                                    input logic xv, input logic yv, input logic last,
                                    input int reps, input logic typed, input int dist_val,
                                    input logic nd, input int used);
        vector_row_t row;
        row.mode          = mode;
        row.x             = SAMPLE_W'(x);
        row.y             = SAMPLE_W'(y);
        row.xv            = xv;
        row.yv            = yv;
        row.last          = last;
        row.reps          = 16'(reps);
        row.typed         = typed;
        row.want.dist_val = mvd_pkg::DIST_W'(dist_val);
        row.want.no_data  = nd;
        row.want.used     = mvd_pkg::CNT_W'(used);
        directed_rows.push_back(row);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] extreme_sample();
        case ($urandom_range(3))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_pair(input logic signed [SAMPLE_W-1:0] xs,
                             input logic signed [SAMPLE_W-1:0] ys,
                             input logic xv, input logic yv, input logic last,
                             input logic typed, input distance_beat_t want);
        distance_beat_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid   <= 1'b1;
        x_sample     <= xs;
        y_sample     <= ys;
        x_valid      <= xv;
        y_valid      <= yv;
        last_element <= last;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (accumulate_pair(xs, ys, xv, yv, last, res))
            expected_distances.push_back(typed ? want : res);
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        item_valid <= 1'b0;
        @(negedge clk);
        while (expected_distances.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_metric_mode(input logic mode);
        logic [mvd_pkg::PDATA_W-1:0] wdata;
        wdata    = $urandom;
        wdata[0] = mode;
        hold_until_drained();
        repeat (DRAIN_PAD) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mvd_pkg::REG_METRIC_MODE;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        cur_mode = mode;
        @(negedge clk);
        if (prdata !== mvd_pkg::PDATA_W'(mode))
        begin
            readback_errors++;
            if (fail_count + readback_errors <= REPORT_MAX)
                $display("metric_mode readback mismatch: expected %0d actual %0d",
                         mode, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_random_vector(inout int sent);
        int                         len;
        int                         style;
        int                         pick;
        logic                       all_missing;
        logic signed [SAMPLE_W-1:0] xs;
        logic signed [SAMPLE_W-1:0] ys;
        logic                       xv;
        logic                       yv;
        pick = $urandom_range(99);
        if (pick < 85)
            len = $urandom_range(8, 1);
        else if (pick < 97)
            len = $urandom_range(40, 9);
        else
            len = $urandom_range(160, 41);
        style       = $urandom_range(3);
        all_missing = ($urandom_range(24) == 0);
        for (int i = 0; i < len; i++)
        begin
            case (style)
                0:
                begin
                    xs = SAMPLE_W'($urandom);
                    ys = SAMPLE_W'($urandom);
                end
                1:
                begin
                    xs = SAMPLE_W'($urandom_range(2047) - 1024);
                    ys = SAMPLE_W'(xs + $urandom_range(63) - 32);
                end
                2:
                begin
                    xs = extreme_sample();
                    ys = extreme_sample();
                end
                default:
                begin
                    xs = SAMPLE_W'($urandom);
                    ys = SAMPLE_W'(xs ^ $urandom_range(255));
                end
            endcase
            if (all_missing)
            begin
                xv = 1'($urandom);
                yv = ~xv & 1'($urandom);
            end
            else if ($urandom_range(99) < 80)
            begin
                xv = 1'b1;
                yv = 1'b1;
            end
            else
            begin
                xv = 1'($urandom);
                yv = 1'($urandom);
            end
            send_pair(xs, ys, xv, yv, i == len - 1, 1'b0, '0);
            sent++;
        end
    endtask

    initial
    begin
        vector_row_t row;
        int          sent;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        item_valid   = 1'b0;
        x_sample     = '0;
        y_sample     = '0;
        x_valid      = 1'b0;
        y_valid      = 1'b0;
        last_element = 1'b0;
        run_sum      = 0;
        run_pairs    = 0;
        cur_mode     = mvd_pkg::MODE_RMS;

        //       mode                    x       y  xv yv lst reps typ   dist nd used
        add_row(mvd_pkg::MODE_RMS,      0,      0, 0, 0, 1,   1, 1,     0, 1,   0);
        add_row(mvd_pkg::MODE_RMS,  32767, -32768, 1, 1, 1,   1, 1, 65535, 0,   1);
        add_row(mvd_pkg::MODE_RMS, -32768,  32767, 1, 1, 1,   1, 1, 65535, 0,   1);
        add_row(mvd_pkg::MODE_RMS,    100,    100, 1, 1, 1,   1, 1,     0, 0,   1);
        add_row(mvd_pkg::MODE_RMS,      5,      9, 1, 0, 0,   1, 0,     0, 0,   0);
        add_row(mvd_pkg::MODE_RMS,      5,      9, 0, 1, 0,   1, 0,     0, 0,   0);
        add_row(mvd_pkg::MODE_RMS,    768,    256, 1, 1, 1,   1, 1,   512, 0,   1);
        add_row(mvd_pkg::MODE_RMS,      1,      0, 1, 1, 1,  40, 1,     1, 0,  40);
        add_row(mvd_pkg::MODE_RMS,  -1234,   5678, 1, 1, 0,   1, 0,     0, 0,   0);
        add_row(mvd_pkg::MODE_RMS,    300,     -7, 1, 1, 1,   1, 0,     0, 0,   0);
        add_row(mvd_pkg::MODE_RMS, -32768, -32768, 0, 0, 1,   1, 1,     0, 1,   0);
        add_row(mvd_pkg::MODE_RMS,     10,      0, 1, 1, 0,   1, 0,     0, 0,   0);
        add_row(mvd_pkg::MODE_RMS,  32767,  32767, 0, 0, 1,   1, 0,     0, 0,   0);
        add_row(mvd_pkg::MODE_MAD,    256,      0, 1, 1, 1,   1, 1,   256, 0,   1);
        add_row(mvd_pkg::MODE_MAD,  32767, -32768, 1, 1, 1,   1, 1, 65535, 0,   1);
        add_row(mvd_pkg::MODE_MAD, -32768, -32768, 1, 1, 1,   1, 1,     0, 0,   1);
        add_row(mvd_pkg::MODE_MAD,      0,      0, 0, 1, 1,   1, 1,     0, 1,   0);
        add_row(mvd_pkg::MODE_MAD, -32768,  32767, 1, 1, 1,  40, 1, 65535, 0,  40);
        add_row(mvd_pkg::MODE_MAD,      7,      3, 1, 1, 0,   1, 0,     0, 0,   0);
        add_row(mvd_pkg::MODE_MAD,      3,      7, 1, 1, 1,   1, 0,     0, 0,   0);
        add_row(mvd_pkg::MODE_MAD,  12345,   -321, 1, 1, 1,   1, 0,     0, 0,   0);
        add_row(mvd_pkg::MODE_RMS,  32767, -32768, 1, 1, 1,  40, 1, 65535, 0,  40);
        add_row(mvd_pkg::MODE_RMS,      2,     -3, 1, 1, 0,   1, 0,     0, 0,   0);
        add_row(mvd_pkg::MODE_RMS,     -4,      4, 1, 1, 1,   1, 0,     0, 0,   0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            if (row.mode != cur_mode)
                write_metric_mode(row.mode);
            for (int k = 1; k <= row.reps; k++)
                send_pair(row.x, row.y, row.xv, row.yv, row.last && (k == row.reps),
                          row.typed, row.want);
        end

        // idling profiles: none, sender, receiver, both light; each in both metrics
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_metric_mode(p[0] ? mvd_pkg::MODE_MAD : mvd_pkg::MODE_RMS);
            case (p / 2)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 73;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 73;
                end
                default:
                begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 8;
                end
            endcase
            sent = 0;
            while (sent < PHASE_PAIRS)
            begin
                if ($urandom_range(49) == 0)
                    hold_until_drained();
                send_random_vector(sent);
            end
        end

        hold_until_drained();
        repeat (TAIL_PAD) @(posedge clk);
        if (fail_count + readback_errors + expected_distances.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
